// ===== design/pfswl_pkg.sv =====
// ----------------------------------------------------------------------------
// pfswl_pkg
// Shared types and constants for the per-flow sliding window limiter.
// ----------------------------------------------------------------------------
package pfswl_pkg;

    localparam int NUM_FLOWS = 256;
    localparam int LOG_DEPTH = 8;

    localparam int FLOW_W  = 8;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = $clog2(LOG_DEPTH);
    localparam int FILL_W  = $clog2(LOG_DEPTH + 1);
    localparam int STAMP_AW = FLOW_W + SLOT_W;

    localparam int MAX_W    = 4;
    localparam int WINDOW_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'd1;

    localparam logic [MAX_W-1:0]    MAX_RESET    = 4'd5;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd60;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LOG_DEPTH);

    typedef struct packed {
        logic [FLOW_W-1:0] flow_index;
        logic [TIME_W-1:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic              allowed;
        logic [FILL_W-1:0] log_count;
    } out_item_t;

    // per-flow ring pointers
    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [FILL_W-1:0] fill;
    } meta_t;

endpackage

// ===== design/pfswl_meta_mem.sv =====
// ----------------------------------------------------------------------------
// pfswl_meta_mem
// Per-flow head/fill store; one read and one write port, registered read.
// Entries not yet written read as an empty log.
// ----------------------------------------------------------------------------
module pfswl_meta_mem
    import pfswl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [FLOW_W-1:0] rd_addr,
    output meta_t             rd_data,
    input  logic              wr_en,
    input  logic [FLOW_W-1:0] wr_addr,
    input  meta_t             wr_data
);

    meta_t                mem [NUM_FLOWS];
    logic [NUM_FLOWS-1:0] written_reg;
    meta_t                rd_mem_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= written_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

// ===== design/pfswl_stamp_mem.sv =====
// ----------------------------------------------------------------------------
// pfswl_stamp_mem
// Time stamp store, one ring of LOG_DEPTH slots per flow; registered read.
// ----------------------------------------------------------------------------
module pfswl_stamp_mem
    import pfswl_pkg::*;
(
    input  logic                clk,
    input  logic                rd_en,
    input  logic [STAMP_AW-1:0] rd_addr,
    output logic [TIME_W-1:0]   rd_data,
    input  logic                wr_en,
    input  logic [STAMP_AW-1:0] wr_addr,
    input  logic [TIME_W-1:0]   wr_data
);

    logic [TIME_W-1:0] mem [NUM_FLOWS * LOG_DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/per_flow_sliding_window_limiter.sv =====
// ----------------------------------------------------------------------------
// per_flow_sliding_window_limiter
// Sliding window log rate limiter over hashed flows.
// ----------------------------------------------------------------------------
// One request at a time: a request reads the flow's meta entry and, when the
// log is not empty, examines its stamps: one per expired stamp popped, plus
// the unexpired stamp that stops the walk unless the log empties first (at
// most LOG_DEPTH = 8). The walk is paced by the stamp memory's single read
// port: expiry walks the log one stamp per cycle from the oldest. The final
// step also waits while an earlier result is still held. Every request gives
// one result (allowed, log_count); the result register lets the next request
// start while a result waits to be taken.
module per_flow_sliding_window_limiter
    import pfswl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_META   = 4'b0010,
        S_CHECK  = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [MAX_W-1:0]    max_reg;
    logic [WINDOW_W-1:0] window_reg;

    logic [FLOW_W-1:0] flow_reg, flow_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic              meta_rd_en;
    meta_t             meta_rd_data;
    logic              meta_wr_en;
    meta_t             meta_wr_data;

    logic                stamp_rd_en;
    logic [STAMP_AW-1:0] stamp_rd_addr;
    logic [TIME_W-1:0]   stamp_rd_data;
    logic                stamp_wr_en;
    logic [STAMP_AW-1:0] stamp_wr_addr;

    logic [FILL_W-1:0] limit;
    logic [FILL_W-1:0] meta_fill_sat;
    logic              expired;
    logic [SLOT_W-1:0] head_inc;
    logic [FILL_W-1:0] fill_dec;
    logic              grant;

    pfswl_meta_mem u_meta (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (meta_rd_en),
        .rd_addr (in_data.flow_index),
        .rd_data (meta_rd_data),
        .wr_en   (meta_wr_en),
        .wr_addr (flow_reg),
        .wr_data (meta_wr_data)
    );

    pfswl_stamp_mem u_stamp (
        .clk     (clk),
        .rd_en   (stamp_rd_en),
        .rd_addr (stamp_rd_addr),
        .rd_data (stamp_rd_data),
        .wr_en   (stamp_wr_en),
        .wr_addr (stamp_wr_addr),
        .wr_data (now_reg)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= MAX_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_PER_WINDOW: max_reg    <= cfg_data[MAX_W-1:0];
                CFG_WINDOW_SECONDS: window_reg <= cfg_data[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    assign limit = (max_reg > MAX_W'(LOG_DEPTH)) ? FILL_FULL : FILL_W'(max_reg);
    assign meta_fill_sat = (meta_rd_data.fill > FILL_FULL) ? FILL_FULL : meta_rd_data.fill;

    // stamp + window < now, in 33-bit arithmetic so nothing wraps
    assign expired  = ({1'b0, stamp_rd_data} + {{(TIME_W + 1 - WINDOW_W){1'b0}}, window_reg})
                      < {1'b0, now_reg};
    assign head_inc = head_reg + SLOT_W'(1);
    assign fill_dec = fill_reg - FILL_W'(1);
    assign grant    = fill_reg < limit;

    always_comb
    begin
        state_next     = state_reg;
        flow_next      = flow_reg;
        now_next       = now_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        meta_rd_en     = 1'b0;
        meta_wr_en     = 1'b0;
        meta_wr_data   = '0;
        stamp_rd_en    = 1'b0;
        stamp_rd_addr  = {flow_reg, head_reg};
        stamp_wr_en    = 1'b0;
        stamp_wr_addr  = {flow_reg, SLOT_W'(head_reg + fill_reg[SLOT_W-1:0])};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    flow_next  = in_data.flow_index;
                    now_next   = in_data.now_seconds;
                    meta_rd_en = 1'b1;
                    state_next = S_META;
                end
            end
            S_META:
            begin
                head_next = meta_rd_data.head;
                fill_next = meta_fill_sat;
                if (meta_fill_sat == '0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    stamp_rd_en   = 1'b1;
                    stamp_rd_addr = {flow_reg, meta_rd_data.head};
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (expired)
                begin
                    head_next = head_inc;
                    fill_next = fill_dec;
                    if (fill_dec == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        stamp_rd_en   = 1'b1;
                        stamp_rd_addr = {flow_reg, head_inc};
                    end
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    stamp_wr_en  = grant;
                    meta_wr_en   = 1'b1;
                    meta_wr_data = '{head: head_reg,
                                     fill: fill_reg + FILL_W'(grant)};
                    out_valid_next          = 1'b1;
                    out_data_next.allowed   = grant;
                    out_data_next.log_count = fill_reg + FILL_W'(grant);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flow_reg     <= flow_next;
        now_reg      <= now_next;
        head_reg     <= head_next;
        fill_reg     <= fill_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
